>>> rtl/pekm_pkg.sv
// ---------------------------------------------------------------------------
// pekm_pkg: shared constants and types
// Sizes, opcodes and the command and status bundles between controller and
// datapath of the paired-endpoint k-means step.
// ---------------------------------------------------------------------------
package pekm_pkg;

   localparam int MAX_VERTICES  = 16;
   localparam int MAX_TRACKLETS = 1024;

   localparam int COORD_W = 32;
   localparam int VIDX_W  = 4;
   localparam int VCNT_W  = 5;
   localparam int SUM_W   = 44;
   localparam int HIT_W   = 12;
   localparam int TAKEN_W = 11;
   localparam int DIST_W  = 66;
   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W  = 6;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ASSIGN = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic KIND_TRACK  = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;
      logic              issue_valid;
      logic              issue_ep;
      logic              pass2;
      logic              scan_clear;
      logic [VIDX_W-1:0] idx;
      logic              acc0;
      logic              acc1;
      logic              emit_track;
      logic              div_start;
      logic              div_step;
      logic              emit_vertex;
      logic              last;
      logic              clear_acc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [VCNT_W-1:0] active_n;
      logic [VIDX_W-1:0] bk;
      logic              slot_free;
      logic              count_zero;
   } status_type;

endpackage

>>> rtl/pekm_ctrl.sv
// ---------------------------------------------------------------------------
// pekm_ctrl: sequencer
// Walks the vertex scans of an assignment, the accumulation, and the
// per-vertex divide and emit of an update.
// ---------------------------------------------------------------------------
module pekm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  pekm_pkg::status_type status,
   output pekm_pkg::cmd_type    cmd
);
   import pekm_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN1  = 4'd1;
   localparam logic [3:0] S_DRAIN1 = 4'd2;
   localparam logic [3:0] S_SCAN2  = 4'd3;
   localparam logic [3:0] S_DRAIN2 = 4'd4;
   localparam logic [3:0] S_ACC0   = 4'd5;
   localparam logic [3:0] S_ACC1   = 4'd6;
   localparam logic [3:0] S_TEMIT  = 4'd7;
   localparam logic [3:0] S_USTART = 4'd8;
   localparam logic [3:0] S_UDIV   = 4'd9;
   localparam logic [3:0] S_UEMIT  = 4'd10;
   localparam logic [3:0] S_UCLEAR = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [VIDX_W-1:0] idx_ff, idx_in;
   logic              ep_ff, ep_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              accept;
   logic              idx_last;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign idx_last  = ({1'b0, idx_ff} == (status.active_n - VCNT_W'(1)));

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ep_in    = ep_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      cmd.issue_ep = ep_ff;
      cmd.last = idx_last;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == OP_ASSIGN) begin
               cmd.capture    = 1'b1;
               cmd.scan_clear = 1'b1;
               idx_in   = '0;
               ep_in    = 1'b0;
               state_in = S_SCAN1;
            end else if (accept && req_opcode == OP_UPDATE) begin
               idx_in   = '0;
               state_in = S_USTART;
            end
         end
         S_SCAN1: begin
            cmd.issue_valid = 1'b1;
            if (idx_last) begin
               idx_in = '0;
               if (ep_ff) begin
                  cnt_in   = '0;
                  state_in = S_DRAIN1;
               end else begin
                  ep_in = 1'b1;
               end
            end else begin
               idx_in = idx_ff + VIDX_W'(1);
            end
         end
         S_DRAIN1: begin
            // Wait until the last candidate has passed the minimum stage.
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(2)) begin
               cmd.scan_clear = 1'b1;
               idx_in   = '0;
               state_in = S_SCAN2;
            end
         end
         S_SCAN2: begin
            // The pass skips the vertex already taken by the closest pair.
            cmd.pass2       = 1'b1;
            cmd.issue_valid = (idx_ff != status.bk);
            if (idx_last) begin
               cnt_in   = '0;
               state_in = S_DRAIN2;
            end else begin
               idx_in = idx_ff + VIDX_W'(1);
            end
         end
         S_DRAIN2: begin
            cmd.pass2 = 1'b1;
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               state_in = S_ACC0;
            end
         end
         S_ACC0: begin
            cmd.acc0 = 1'b1;
            state_in = S_ACC1;
         end
         S_ACC1: begin
            cmd.acc1 = 1'b1;
            state_in = S_TEMIT;
         end
         S_TEMIT: begin
            if (status.slot_free) begin
               cmd.emit_track = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_USTART: begin
            cmd.div_start = 1'b1;
            cnt_in = '0;
            state_in = status.count_zero ? S_UEMIT : S_UDIV;
         end
         S_UDIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_UEMIT;
            end
         end
         S_UEMIT: begin
            if (status.slot_free) begin
               cmd.emit_vertex = 1'b1;
               if (idx_last) begin
                  state_in = S_UCLEAR;
               end else begin
                  idx_in   = idx_ff + VIDX_W'(1);
                  state_in = S_USTART;
               end
            end
         end
         S_UCLEAR: begin
            cmd.clear_acc = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         ep_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         ep_ff    <= ep_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/pekm_dpath.sv
// ---------------------------------------------------------------------------
// pekm_dpath: storage and arithmetic
// Vertex and accumulator storage, a three-stage distance pipeline, the
// running minimum, three restoring divider lanes and the result register.
// ---------------------------------------------------------------------------
module pekm_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  pekm_pkg::cmd_type            cmd,
   output pekm_pkg::status_type         status,
   input  logic                         csr_wr_en,
   input  logic [pekm_pkg::VCNT_W-1:0]  csr_wr_data,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [pekm_pkg::VIDX_W-1:0]  req_vertex_slot,
   input  pekm_pkg::coord_type          req_first_x,
   input  pekm_pkg::coord_type          req_first_y,
   input  pekm_pkg::coord_type          req_first_z,
   input  pekm_pkg::coord_type          req_second_x,
   input  pekm_pkg::coord_type          req_second_y,
   input  pekm_pkg::coord_type          req_second_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [pekm_pkg::VIDX_W-1:0]  rsp_first_vertex,
   output logic [pekm_pkg::VIDX_W-1:0]  rsp_second_vertex,
   output logic                         rsp_rejected,
   output logic [pekm_pkg::VIDX_W-1:0]  rsp_out_index,
   output pekm_pkg::coord_type          rsp_out_x,
   output pekm_pkg::coord_type          rsp_out_y,
   output pekm_pkg::coord_type          rsp_out_z,
   output logic [pekm_pkg::HIT_W-1:0]   rsp_member_count,
   output logic                         rsp_last
);
   import pekm_pkg::*;

   logic [VCNT_W-1:0]         vcount_ff;
   coord_type                 ep_ff [0:1][0:2];
   coord_type                 vert_ff [0:2][MAX_VERTICES];
   logic signed [SUM_W-1:0]   sum_ff [0:2][MAX_VERTICES];
   logic [HIT_W-1:0]          hit_ff [MAX_VERTICES];
   logic [TAKEN_W-1:0]        taken_ff;
   logic                      rej_ff;

   logic [COORD_W-1:0]        s1_mag_ff [0:2];
   logic                      s1_valid_ff, s1_pass2_ff, s1_ep_ff;
   logic [VIDX_W-1:0]         s1_idx_ff;
   logic [2*COORD_W-1:0]      s2_sq_ff [0:2];
   logic                      s2_valid_ff, s2_pass2_ff, s2_ep_ff;
   logic [VIDX_W-1:0]         s2_idx_ff;

   logic [DIST_W-1:0]         best_ff;
   logic                      have_ff, bj_ff;
   logic [VIDX_W-1:0]         bk_ff, ok_ff;

   logic [SUM_W-1:0]          dnum_ff [0:2];
   logic [HIT_W-1:0]          drem_ff [0:2];
   logic                      dneg_ff [0:2];
   logic [HIT_W-1:0]          dden_ff;

   logic                      rsp_valid_ff;
   logic [DIST_W-1:0]         span_sum;
   logic                      accept;
   logic                      issue_sel;
   logic [VIDX_W-1:0]         asg0, asg1, acc_idx;
   logic                      rej_now;
   coord_type                 quot [0:2];
   logic [VCNT_W-1:0]         active_n;

   assign accept = req_valid && !req_stall;

   // The second scan measures the endpoint that lost the closest pair.
   assign issue_sel = cmd.pass2 ? !bj_ff : cmd.issue_ep;

   // Active vertex count: zero means one, large values saturate.
   always_comb begin
      if (vcount_ff == '0) begin
         active_n = VCNT_W'(1);
      end else if (vcount_ff > VCNT_W'(MAX_VERTICES)) begin
         active_n = VCNT_W'(MAX_VERTICES);
      end else begin
         active_n = vcount_ff;
      end
   end

   assign asg0    = bj_ff ? ok_ff : bk_ff;
   assign asg1    = bj_ff ? bk_ff : ok_ff;
   assign acc_idx = cmd.acc1 ? asg1 : asg0;
   assign rej_now = (taken_ff >= TAKEN_W'(MAX_TRACKLETS));

   assign status.active_n   = active_n;
   assign status.bk         = bk_ff;
   assign status.slot_free  = !rsp_valid_ff || !rsp_stall;
   assign status.count_zero = (hit_ff[cmd.idx] == '0);

   assign span_sum = DIST_W'(s2_sq_ff[0]) + DIST_W'(s2_sq_ff[1]) + DIST_W'(s2_sq_ff[2]);

   // Signed quotients from the divider lanes.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quot[c] = dneg_ff[c] ? COORD_W'(-dnum_ff[c]) : COORD_W'(dnum_ff[c]);
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCNT_W'(1);
      end else if (csr_wr_en) begin
         vcount_ff <= csr_wr_data;
      end
   end

   // Captured endpoints of the tracklet at work.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ep_ff[0][0] <= req_first_x;
         ep_ff[0][1] <= req_first_y;
         ep_ff[0][2] <= req_first_z;
         ep_ff[1][0] <= req_second_x;
         ep_ff[1][1] <= req_second_y;
         ep_ff[1][2] <= req_second_z;
      end
   end

   // Distance pipeline, stage one: absolute coordinate differences.
   always_ff @(posedge clock) begin
      logic signed [COORD_W:0] d;
      for (int c = 0; c < 3; c++) begin
         d = {ep_ff[issue_sel][c][COORD_W-1], ep_ff[issue_sel][c]}
           - {vert_ff[c][cmd.idx][COORD_W-1], vert_ff[c][cmd.idx]};
         s1_mag_ff[c] <= d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
      end
      s1_pass2_ff <= cmd.pass2;
      s1_ep_ff    <= issue_sel;
      s1_idx_ff   <= cmd.idx;
   end

   // Stage two: squares, one multiplier per axis.
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         s2_sq_ff[c] <= s1_mag_ff[c] * s1_mag_ff[c];
      end
      s2_pass2_ff <= s1_pass2_ff;
      s2_ep_ff    <= s1_ep_ff;
      s2_idx_ff   <= s1_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage three: running minimum; a tie keeps the earlier candidate.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         bj_ff   <= 1'b0;
         bk_ff   <= '0;
         ok_ff   <= '0;
         best_ff <= '0;
      end else if (cmd.scan_clear) begin
         have_ff <= 1'b0;
         ok_ff   <= '0;
      end else if (s2_valid_ff && (!have_ff || span_sum < best_ff)) begin
         have_ff <= 1'b1;
         best_ff <= span_sum;
         if (s2_pass2_ff) begin
            ok_ff <= s2_idx_ff;
         end else begin
            bj_ff <= s2_ep_ff;
            bk_ff <= s2_idx_ff;
         end
      end
   end

   // Vertex positions: loads and update write-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < MAX_VERTICES; k++) begin
               vert_ff[c][k] <= '0;
            end
         end
      end else if (accept && req_opcode == OP_LOAD) begin
         vert_ff[0][req_vertex_slot] <= req_first_x;
         vert_ff[1][req_vertex_slot] <= req_first_y;
         vert_ff[2][req_vertex_slot] <= req_first_z;
      end else if (cmd.emit_vertex) begin
         for (int c = 0; c < 3; c++) begin
            vert_ff[c][cmd.idx] <= (hit_ff[cmd.idx] == '0) ? '0 : quot[c];
         end
      end
   end

   // Accumulators: one endpoint per cycle, cleared at the end of an update.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_acc) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < MAX_VERTICES; k++) begin
               sum_ff[c][k] <= '0;
            end
         end
         for (int k = 0; k < MAX_VERTICES; k++) begin
            hit_ff[k] <= '0;
         end
         taken_ff <= '0;
         rej_ff   <= 1'b0;
      end else if ((cmd.acc0 && !rej_now) || (cmd.acc1 && !rej_ff)) begin
         for (int c = 0; c < 3; c++) begin
            sum_ff[c][acc_idx] <= sum_ff[c][acc_idx]
                                + SUM_W'(ep_ff[cmd.acc1][c]);
         end
         hit_ff[acc_idx] <= hit_ff[acc_idx] + HIT_W'(1);
         if (cmd.acc0) begin
            rej_ff <= 1'b0;
         end else begin
            taken_ff <= taken_ff + TAKEN_W'(1);
         end
      end else if (cmd.acc0) begin
         rej_ff <= 1'b1;
      end
   end

   // Divider lanes: restoring division of the sum magnitude by the count.
   always_ff @(posedge clock) begin
      logic [HIT_W:0] trial;
      if (cmd.div_start) begin
         dden_ff <= hit_ff[cmd.idx];
         for (int c = 0; c < 3; c++) begin
            dneg_ff[c] <= sum_ff[c][cmd.idx][SUM_W-1];
            dnum_ff[c] <= sum_ff[c][cmd.idx][SUM_W-1] ? SUM_W'(-sum_ff[c][cmd.idx])
                                                     : SUM_W'(sum_ff[c][cmd.idx]);
            drem_ff[c] <= '0;
         end
      end else if (cmd.div_step) begin
         for (int c = 0; c < 3; c++) begin
            trial = {drem_ff[c], dnum_ff[c][SUM_W-1]};
            if (trial >= {1'b0, dden_ff}) begin
               drem_ff[c] <= HIT_W'(trial - {1'b0, dden_ff});
               dnum_ff[c] <= {dnum_ff[c][SUM_W-2:0], 1'b1};
            end else begin
               drem_ff[c] <= trial[HIT_W-1:0];
               dnum_ff[c] <= {dnum_ff[c][SUM_W-2:0], 1'b0};
            end
         end
      end
   end

   // Result register: holds a beat until the far side takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_track || cmd.emit_vertex) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_track) begin
         rsp_kind          <= KIND_TRACK;
         rsp_first_vertex  <= asg0;
         rsp_second_vertex <= asg1;
         rsp_rejected      <= rej_ff;
         rsp_out_index     <= '0;
         rsp_out_x         <= '0;
         rsp_out_y         <= '0;
         rsp_out_z         <= '0;
         rsp_member_count  <= '0;
         rsp_last          <= 1'b1;
      end else if (cmd.emit_vertex) begin
         rsp_kind          <= KIND_VERTEX;
         rsp_first_vertex  <= '0;
         rsp_second_vertex <= '0;
         rsp_rejected      <= 1'b0;
         rsp_out_index     <= cmd.idx;
         rsp_out_x         <= (hit_ff[cmd.idx] == '0) ? '0 : quot[0];
         rsp_out_y         <= (hit_ff[cmd.idx] == '0) ? '0 : quot[1];
         rsp_out_z         <= (hit_ff[cmd.idx] == '0) ? '0 : quot[2];
         rsp_member_count  <= hit_ff[cmd.idx];
         rsp_last          <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/paired_endpoint_kmeans_step.sv
// ---------------------------------------------------------------------------
// paired_endpoint_kmeans_step: one constrained k-means iteration
// An assignment passes one vertex per cycle through the distance pipeline
// in two scans; an update divides vertex by vertex in the one-bit-per-cycle
// divider lanes. Reset is synchronous and clears all vertices, accumulators
// and the tracklet count, and sets the vertex count to one.
// ---------------------------------------------------------------------------
module paired_endpoint_kmeans_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [pekm_pkg::VCNT_W-1:0]  csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [pekm_pkg::VIDX_W-1:0]  req_vertex_slot,
   input  pekm_pkg::coord_type          req_first_x,
   input  pekm_pkg::coord_type          req_first_y,
   input  pekm_pkg::coord_type          req_first_z,
   input  pekm_pkg::coord_type          req_second_x,
   input  pekm_pkg::coord_type          req_second_y,
   input  pekm_pkg::coord_type          req_second_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [pekm_pkg::VIDX_W-1:0]  rsp_first_vertex,
   output logic [pekm_pkg::VIDX_W-1:0]  rsp_second_vertex,
   output logic                         rsp_rejected,
   output logic [pekm_pkg::VIDX_W-1:0]  rsp_out_index,
   output pekm_pkg::coord_type          rsp_out_x,
   output pekm_pkg::coord_type          rsp_out_y,
   output pekm_pkg::coord_type          rsp_out_z,
   output logic [pekm_pkg::HIT_W-1:0]   rsp_member_count,
   output logic                         rsp_last
);
   import pekm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   pekm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   // Storage and arithmetic.
   pekm_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_vertex_slot   (req_vertex_slot),
      .req_first_x       (req_first_x),
      .req_first_y       (req_first_y),
      .req_first_z       (req_first_z),
      .req_second_x      (req_second_x),
      .req_second_y      (req_second_y),
      .req_second_z      (req_second_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_first_vertex  (rsp_first_vertex),
      .rsp_second_vertex (rsp_second_vertex),
      .rsp_rejected      (rsp_rejected),
      .rsp_out_index     (rsp_out_index),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_member_count  (rsp_member_count),
      .rsp_last          (rsp_last)
   );

endmodule

>>> tb/sv/paired_endpoint_kmeans_step_tb.sv
// ---------------------------------------------------------------------------
// paired_endpoint_kmeans_step_tb: self-checking bench for the k-means step
// Drives load, assign and update beats with random gaps and random response
// stalls. A behavioral predictor keeps its own vertex and accumulator state
// and queues the expected responses. Every response beat is compared field
// by field against the oldest expectation.
// ---------------------------------------------------------------------------
module paired_endpoint_kmeans_step_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pekm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 60;

   typedef struct {
      logic [1:0]  op;
      logic [3:0]  slot;
      logic [31:0] c [6];
   } beat_type;

   typedef struct {
      logic        kind;
      logic [3:0]  fv;
      logic [3:0]  sv;
      logic        rej;
      logic [3:0]  idx;
      logic [31:0] x, y, z;
      logic [11:0] cnt;
      logic        last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [VCNT_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_opcode = '0;
   logic [VIDX_W-1:0] req_vertex_slot = '0;
   coord_type req_first_x = '0, req_first_y = '0, req_first_z = '0;
   coord_type req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic rsp_kind, rsp_rejected, rsp_last;
   logic [VIDX_W-1:0] rsp_first_vertex, rsp_second_vertex, rsp_out_index;
   coord_type rsp_out_x, rsp_out_y, rsp_out_z;
   logic [HIT_W-1:0] rsp_member_count;

   // Predictor state.
   longint vert_pos [16][3];
   longint coord_sum [16][3];
   int     hits [16];
   int     taken;
   int     vcount;
   result_type pending_results [$];

   int errors = 0;
   int cycles = 0;
   bit quiet_send = 0;
   bit quiet_recv = 0;
   bit long_hold = 0;

   paired_endpoint_kmeans_step dut (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_valid, .req_stall, .req_opcode, .req_vertex_slot,
      .req_first_x, .req_first_y, .req_first_z,
      .req_second_x, .req_second_y, .req_second_z,
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_first_vertex, .rsp_second_vertex,
      .rsp_rejected, .rsp_out_index, .rsp_out_x, .rsp_out_y, .rsp_out_z,
      .rsp_member_count, .rsp_last
   );

   always #2 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int active_count();
      if (vcount == 0) return 1;
      if (vcount > 16) return 16;
      return vcount;
   endfunction

   // Appends one expected beat at the tail of the queue.
   function automatic void queue_result(result_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   // Exact squared distance from an endpoint to a vertex, 66 bits wide.
   function automatic logic [65:0] sq_span(longint p [3], int k);
      logic [65:0] acc, m;
      longint d;
      acc = '0;
      for (int a = 0; a < 3; a++) begin
         d = p[a] - vert_pos[k][a];
         m = (d < 0) ? 66'(-d) : 66'(d);
         acc = acc + m * m;
      end
      return acc;
   endfunction

   function automatic void assign_tracklet(beat_type b);
      longint ep [2][3];
      logic [65:0] best, d;
      int bj, bk, ok, n;
      bit have;
      int asg [2];
      result_type r;
      n = active_count();
      for (int j = 0; j < 2; j++)
         for (int a = 0; a < 3; a++)
            ep[j][a] = longint'($signed(b.c[j*3+a]));
      have = 0; best = '0; bj = 0; bk = 0; ok = 0;
      for (int j = 0; j < 2; j++)
         for (int k = 0; k < n; k++) begin
            d = sq_span(ep[j], k);
            if (!have || d < best) begin
               best = d; bj = j; bk = k; have = 1;
            end
         end
      // The other endpoint takes the nearest vertex that is still free.
      have = 0;
      for (int k = 0; k < n; k++) begin
         if (k == bk) continue;
         d = sq_span(ep[1-bj], k);
         if (!have || d < best) begin
            best = d; ok = k; have = 1;
         end
      end
      asg[bj] = bk;
      asg[1-bj] = have ? ok : 0;
      r = '{default: '0};
      r.kind = KIND_TRACK;
      r.fv = 4'(asg[0]);
      r.sv = 4'(asg[1]);
      r.rej = (taken >= MAX_TRACKLETS);
      r.last = 1'b1;
      if (!r.rej) begin
         for (int j = 0; j < 2; j++) begin
            for (int a = 0; a < 3; a++) coord_sum[asg[j]][a] += ep[j][a];
            hits[asg[j]]++;
         end
         taken++;
      end
      queue_result(r);
   endfunction

   function automatic void update_vertices();
      int n;
      result_type r;
      n = active_count();
      for (int k = 0; k < n; k++) begin
         for (int a = 0; a < 3; a++)
            vert_pos[k][a] = (hits[k] != 0) ? coord_sum[k][a] / hits[k] : 0;
         r = '{default: '0};
         r.kind = KIND_VERTEX;
         r.idx = 4'(k);
         r.x = vert_pos[k][0][31:0];
         r.y = vert_pos[k][1][31:0];
         r.z = vert_pos[k][2][31:0];
         r.cnt = (hits[k] > 4095) ? 12'd4095 : 12'(hits[k]);
         r.last = (k == n - 1);
         queue_result(r);
      end
      for (int k = 0; k < 16; k++) begin
         hits[k] = 0;
         for (int a = 0; a < 3; a++) coord_sum[k][a] = 0;
      end
      taken = 0;
   endfunction

   function automatic void predict_beat(beat_type b);
      case (b.op)
         OP_LOAD: begin
            for (int a = 0; a < 3; a++)
               vert_pos[b.slot][a] = longint'($signed(b.c[a]));
         end
         OP_ASSIGN: assign_tracklet(b);
         OP_UPDATE: update_vertices();
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // Response checker: each accepted beat against the oldest expectation.
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat", rsp_kind, 0);
         end else begin
            e = pending_results.pop_front();
            if (rsp_kind !== e.kind) report_mismatch("kind", rsp_kind, e.kind);
            if (rsp_first_vertex !== e.fv)
               report_mismatch("first_vertex", rsp_first_vertex, e.fv);
            if (rsp_second_vertex !== e.sv)
               report_mismatch("second_vertex", rsp_second_vertex, e.sv);
            if (rsp_rejected !== e.rej) report_mismatch("rejected", rsp_rejected, e.rej);
            if (rsp_out_index !== e.idx) report_mismatch("out_index", rsp_out_index, e.idx);
            if (rsp_out_x !== e.x) report_mismatch("out_x", rsp_out_x, e.x);
            if (rsp_out_y !== e.y) report_mismatch("out_y", rsp_out_y, e.y);
            if (rsp_out_z !== e.z) report_mismatch("out_z", rsp_out_z, e.z);
            if (rsp_member_count !== e.cnt)
               report_mismatch("member_count", rsp_member_count, e.cnt);
            if (rsp_last !== e.last) report_mismatch("last", rsp_last, e.last);
         end
      end
   end

   // Response stall: a random wait before each beat, or a long hold on request.
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            long_hold = 0;
         end
         wait_cycles = quiet_recv ? 0 : $urandom_range(0, 16);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Send one request beat; returns in the step where it was accepted.
   task automatic send_beat(beat_type b);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= b.op;
      req_vertex_slot <= b.slot;
      req_first_x <= b.c[0];
      req_first_y <= b.c[1];
      req_first_z <= b.c[2];
      req_second_x <= b.c[3];
      req_second_y <= b.c[4];
      req_second_z <= b.c[5];
      do @(posedge clock); while (req_stall);
      predict_beat(b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_vertex_count(logic [4:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vcount = v;
   endtask

   function automatic logic [31:0] pick_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 4000)) - 2000) <<< 8;
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic beat_type make_beat(logic [1:0] op, logic [3:0] slot, int mode);
      beat_type b;
      b.op = op;
      b.slot = slot;
      for (int i = 0; i < 6; i++) b.c[i] = pick_coord(mode);
      return b;
   endfunction

   function automatic beat_type fixed_beat(logic [1:0] op, logic [3:0] slot,
                                           logic [31:0] p, logic [31:0] q);
      beat_type b;
      b.op = op;
      b.slot = slot;
      for (int i = 0; i < 3; i++) begin
         b.c[i] = p;
         b.c[i+3] = q;
      end
      return b;
   endfunction

   // Extremes, ties, the unused opcode, a single vertex and out-of-range counts.
   task automatic test_directed();
      write_vertex_count(5'd4);
      send_beat(fixed_beat(OP_LOAD, 0, 32'h7FFF_FFFF, 0));
      send_beat(fixed_beat(OP_LOAD, 1, 32'h8000_0000, 0));
      send_beat(fixed_beat(OP_LOAD, 2, 0, 0));
      send_beat(fixed_beat(OP_LOAD, 3, 0, 0));
      // Both endpoints at the origin: ties go to the lower endpoint and vertex.
      send_beat(fixed_beat(OP_ASSIGN, 0, 0, 0));
      send_beat(fixed_beat(OP_ASSIGN, 0, 32'h8000_0000, 32'h7FFF_FFFF));
      send_beat(fixed_beat(OP_ASSIGN, 0, 32'h7FFF_FFFF, 32'h8000_0000));
      send_beat(fixed_beat(OP_ASSIGN, 0, 32'h0001_0000, 32'hFFFF_0000));
      send_beat(fixed_beat(OP_UNUSED, 0, 32'h1234_5678, 32'h9ABC_DEF0));
      send_beat(fixed_beat(OP_LOAD, 15, 32'h5555_AAAA, 0));
      send_beat(fixed_beat(OP_UPDATE, 0, 0, 0));
      drain();
      write_vertex_count(5'd1);
      send_beat(fixed_beat(OP_ASSIGN, 0, 32'h0000_0003, 32'hFFFF_FFFD));
      send_beat(fixed_beat(OP_UPDATE, 0, 0, 0));
      drain();
      write_vertex_count(5'd0);
      send_beat(fixed_beat(OP_ASSIGN, 0, 32'hFFFF_FFFF, 32'h0000_0002));
      send_beat(fixed_beat(OP_UPDATE, 0, 0, 0));
      drain();
      write_vertex_count(5'd31);
      send_beat(fixed_beat(OP_ASSIGN, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFE));
      send_beat(fixed_beat(OP_UPDATE, 0, 0, 0));
      drain();
   endtask

   // More tracklets than the pass can hold; the excess must be flagged.
   task automatic test_capacity();
      write_vertex_count(5'd2);
      quiet_send = 1;
      quiet_recv = 1;
      for (int i = 0; i < MAX_TRACKLETS + 8; i++) send_beat(make_beat(OP_ASSIGN, 0, 1));
      send_beat(make_beat(OP_UPDATE, 0, 0));
      quiet_send = 0;
      quiet_recv = 0;
      drain();
   endtask

   // The receiver holds off while requests keep coming, so the block backs up.
   task automatic test_backpressure();
      write_vertex_count(5'd3);
      long_hold = 1;
      quiet_send = 1;
      for (int i = 0; i < 40; i++) send_beat(make_beat(OP_ASSIGN, 0, 1));
      send_beat(make_beat(OP_UPDATE, 0, 1));
      quiet_send = 0;
      drain();
   endtask

   // Random passes: load the active vertices, assign tracklets, then update.
   task automatic test_random_passes();
      int sent, n, mode;
      logic [4:0] counts [6] = '{5'd1, 5'd16, 5'd0, 5'd17, 5'd31, 5'd8};
      sent = 0;
      for (int pass = 0; sent < 310; pass++) begin
         write_vertex_count(pass < 6 ? counts[pass] : 5'($urandom_range(0, 31)));
         n = active_count();
         quiet_send = ($urandom_range(0, 3) == 0);
         quiet_recv = ($urandom_range(0, 3) == 0);
         mode = $urandom_range(0, 2);
         for (int k = 0; k < n; k++) begin
            send_beat(make_beat(OP_LOAD, 4'(k), mode == 2 ? 0 : mode));
            sent++;
         end
         for (int i = $urandom_range(4, 24); i > 0; i--) begin
            case ($urandom_range(0, 9))
               0: send_beat(make_beat(OP_UNUSED, 4'($urandom), 0));
               1: send_beat(make_beat(OP_LOAD, 4'($urandom), 0));
               2: send_beat(make_beat(OP_ASSIGN, 4'($urandom), 2));
               3: send_beat(make_beat(OP_ASSIGN, 4'($urandom), 0));
               default: send_beat(make_beat(OP_ASSIGN, 4'($urandom), 1));
            endcase
            sent++;
         end
         send_beat(make_beat(OP_UPDATE, 4'($urandom), 0));
         sent++;
         drain();
      end
      quiet_send = 0;
      quiet_recv = 0;
   endtask

   initial begin
      for (int k = 0; k < 16; k++) begin
         hits[k] = 0;
         for (int a = 0; a < 3; a++) begin
            vert_pos[k][a] = 0;
            coord_sum[k][a] = 0;
         end
      end
      taken = 0;
      vcount = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity();
      test_backpressure();
      test_random_passes();
      drain();
      if (errors == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
